// ===== rtl/text_number_extract_sort_defines.svh =====
// ----------------------------------------------------------------------------
// text_number_extract_sort_defines - assertion macros
// shared concurrent assertion forms, clocked on clk; one is disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef TEXT_NUMBER_EXTRACT_SORT_DEFINES_SVH
`define TEXT_NUMBER_EXTRACT_SORT_DEFINES_SVH

// property checked only while out of reset
`define TNES_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define TNES_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tnes_pkg.sv =====
// ----------------------------------------------------------------------------
// tnes_pkg - shared types and constants
// character codes, cell control group and sequencer states
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tnes_pkg;

	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [3:0] RADIX    = 4'd10;
	localparam int         OUT_BITS = 32;

	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IN,
		ST_FLUSH,
		ST_DRAIN,
		ST_EMPTY
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/tnes_parse.sv =====
// ----------------------------------------------------------------------------
// tnes_parse - decimal digit run accumulator
// builds the saturating value of the current digit run
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tnes_parse
	import tnes_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  take,
	input  wire logic [7:0]            ch,
	input  wire logic                  flush,
	output logic                       done,
	output logic                       in_run,
	output logic [VALUE_BITS-1:0]      value
);

	localparam int PW = VALUE_BITS + 4;

	logic [VALUE_BITS-1:0] partial_q;
	logic                  inside_q;
	logic                  digit;
	logic [7:0]            diff;
	logic [PW-1:0]         prod;
	logic [VALUE_BITS-1:0] next_val;

	always_comb begin
		digit = ch inside {[CH_ZERO:CH_NINE]};
		diff  = ch - CH_ZERO;
		prod  = PW'(partial_q) * PW'(RADIX) + PW'(diff[3:0]);
		// saturate once the run passes the value width
		if (prod[PW-1:VALUE_BITS] != '0) begin
			next_val = '1;
		end else begin
			next_val = prod[VALUE_BITS-1:0];
		end
	end

	assign done   = take && !digit && inside_q;
	assign in_run = inside_q;
	assign value  = partial_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			inside_q  <= 1'b0;
		end else if (flush || done) begin
			partial_q <= '0;
			inside_q  <= 1'b0;
		end else if (take && digit) begin
			partial_q <= next_val;
			inside_q  <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tnes_cell.sv =====
// ----------------------------------------------------------------------------
// tnes_cell - one slot of the sorted insertion chain
// holds one value, makes room for an insert, shifts toward the head on drain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tnes_cell
	import tnes_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire cell_ctl_t             ctl,
	input  wire logic                  valid,
	input  wire logic [VALUE_BITS-1:0] ins_value,
	input  wire logic                  left_gt,
	input  wire logic [VALUE_BITS-1:0] left_value,
	input  wire logic [VALUE_BITS-1:0] right_value,
	output logic                       gt,
	output logic [VALUE_BITS-1:0]      value
);

	logic [VALUE_BITS-1:0] value_q;

	// an empty slot counts as larger than anything
	assign gt    = !valid || (value_q > ins_value);
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= right_value;
		end else if (ctl.ins && gt) begin
			value_q <= left_gt ? left_value : ins_value;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/text_number_extract_sort.sv =====
// ----------------------------------------------------------------------------
// text_number_extract_sort - extract decimal numbers from text and sort them
// digit runs become saturating integers kept in a sorted chain of cells
// ----------------------------------------------------------------------------
// Text comes in one byte per word on the s_ side, one word per cycle with no
// stall while a string is read: every maximal run of '0'..'9' becomes one
// unsigned number (saturating at 2^VALUE_BITS-1) that is dropped straight
// into its ordered place in a row of MAX_NUMBERS cells, each cell comparing
// against the new value and taking its left neighbor's value in the same
// cycle. The word with tlast closes the string; s_tready then drops for the
// flush state, which stores any pending number, and for the drain, which moves
// the cell row toward the head one step per cycle while the output register
// can take a word, and sends the numbers in ascending order on the m_ side,
// one word per cycle while m_tready is high. A string with no numbers gives
// one marker word with none_found set. Numbers past MAX_NUMBERS are dropped
// and overflowed is set on every word of that burst. The next string is
// taken while the last result word still waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_number_extract_sort
	import tnes_pkg::*;
#(
	parameter int MAX_NUMBERS = 64,
	parameter int VALUE_BITS  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// text input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // is_final
	// sorted numbers out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] number_value
	output logic             m_tlast,   // last_number
	output logic [1:0]       m_tuser    // [0] none_found, [1] overflowed
);

	localparam int CW = $clog2(MAX_NUMBERS + 1);

	state_t                state_q, state_d;
	logic [CW-1:0]         cnt_q;
	logic                  dropped_q;
	logic                  take;
	logic                  p_done;
	logic                  p_inside;
	logic [VALUE_BITS-1:0] p_value;
	logic                  full;
	logic                  ins_req;
	logic                  drop;
	logic                  load_ok;
	logic                  out_load;
	cell_ctl_t             ctl;

	logic [VALUE_BITS-1:0] cell_val [MAX_NUMBERS];
	logic                  cell_gt  [MAX_NUMBERS];
	logic [63:0]           head_ext;

	// output register
	logic                  m_valid_q;
	logic [31:0]           m_data_q;
	logic                  m_last_q;
	logic                  m_none_q;
	logic                  m_ovf_q;

	// digit run parser
	tnes_parse #(
		.VALUE_BITS(VALUE_BITS)
	) u_parse (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.ch    (s_tdata),
		.flush (state_q == ST_FLUSH),
		.done  (p_done),
		.in_run(p_inside),
		.value (p_value)
	);

	// sorted cell row, cell 0 holds the smallest value
	for (genvar i = 0; i < MAX_NUMBERS; i++) begin : g_cell
		logic                  lgt;
		logic [VALUE_BITS-1:0] lval;
		logic [VALUE_BITS-1:0] rval;
		if (i == 0) begin : g_head
			assign lgt  = 1'b0;
			assign lval = '0;
		end else begin : g_mid
			assign lgt  = cell_gt[i-1];
			assign lval = cell_val[i-1];
		end
		if (i == MAX_NUMBERS - 1) begin : g_tail
			assign rval = '0;
		end else begin : g_body
			assign rval = cell_val[i+1];
		end
		tnes_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (CW'(i) < cnt_q),
			.ins_value  (p_value),
			.left_gt    (lgt),
			.left_value (lval),
			.right_value(rval),
			.gt         (cell_gt[i]),
			.value      (cell_val[i])
		);
	end

	assign full     = (cnt_q == CW'(MAX_NUMBERS));
	assign load_ok  = !m_valid_q || m_tready;
	assign head_ext = 64'(cell_val[0]);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IN: begin
				if (take && s_tlast) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (p_inside || cnt_q != '0) state_d = ST_DRAIN;
				else                         state_d = ST_EMPTY;
			end
			ST_DRAIN: begin
				if (load_ok && cnt_q == CW'(1)) state_d = ST_IN;
			end
			ST_EMPTY: begin
				if (load_ok) state_d = ST_IN;
			end
			default: state_d = ST_IN;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready  = (state_q == ST_IN);
		take      = s_tvalid && s_tready;
		// a run ends on a non-digit byte or at the flush after the last byte
		ins_req   = p_done || (state_q == ST_FLUSH && p_inside);
		ctl.ins   = ins_req && !full;
		drop      = ins_req && full;
		ctl.shift = (state_q == ST_DRAIN) && load_ok;
		out_load  = ctl.shift || ((state_q == ST_EMPTY) && load_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IN;
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.ins) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (ctl.shift) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (drop) begin
				dropped_q <= 1'b1;
			end else if (ctl.shift && cnt_q == CW'(1)) begin
				dropped_q <= 1'b0;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// result payload, taken from the head cell or the empty marker
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_EMPTY) begin
				m_data_q <= '0;
				m_last_q <= 1'b1;
				m_none_q <= 1'b1;
				m_ovf_q  <= 1'b0;
			end else begin
				m_data_q <= head_ext[OUT_BITS-1:0];
				m_last_q <= (cnt_q == CW'(1));
				m_none_q <= 1'b0;
				m_ovf_q  <= dropped_q;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = {m_ovf_q, m_none_q};

`include "text_number_extract_sort_defines.svh"

	// the fill count never passes the row length
	`TNES_ASSERT_ALWAYS(a_cnt_range, (cnt_q <= CW'(MAX_NUMBERS)), "fill count out of range")
	// an insert and a drain shift never meet in one cycle
	`TNES_ASSERT(a_ins_shift, (!(ctl.ins && ctl.shift)), "insert during drain")
	// a drain step always has a stored number behind it
	`TNES_ASSERT(a_drain_cnt, (ctl.shift |-> cnt_q != '0), "drain with empty row")
	// the empty marker is a lone zero word without overflow
	`TNES_ASSERT(a_marker, (m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == '0 && !m_tuser[1]), "bad empty marker")

endmodule

`default_nettype wire
